### rtl/bcdso_pkg.sv
// ----------------------------------------------------------------------------
// bcdso_pkg
// Shared constants and types for the BCD digit shift-out driver.
// ----------------------------------------------------------------------------
package bcdso_pkg;

   localparam int VALUE_W        = 16;
   localparam int DIGITS         = 4;
   localparam int KNOWN_DIGITS   = 4;
   localparam int BITS_PER_DIGIT = 4;
   localparam int BCD_DIGITS     = 5;
   localparam int BCD_W          = BCD_DIGITS * BITS_PER_DIGIT;
   localparam int BIT_COUNT      = DIGITS * BITS_PER_DIGIT;
   localparam int STEP_W         = $clog2(VALUE_W);
   localparam int POS_W          = $clog2(BIT_COUNT + 1);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BIT_COUNT-1:0] digits_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

### rtl/bcdso_front.sv
// ----------------------------------------------------------------------------
// bcdso_front
// Accepts a value and converts it to packed BCD with one double-dabble step
// per cycle, last step held while queue is full, then pushes the low digits.
// ----------------------------------------------------------------------------
module bcdso_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bcdso_pkg::VALUE_W-1:0] req_value,
   input  bcdso_pkg::q_stat_type        q_stat,
   output logic                         push,
   output bcdso_pkg::digits_type        push_data
);

   logic                            busy_ff, busy_in;
   logic [bcdso_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [bcdso_pkg::VALUE_W-1:0]   bin_ff, bin_in;
   logic [bcdso_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [bcdso_pkg::BCD_W-1:0]     adj;
   logic [bcdso_pkg::BCD_W-1:0]     bcd_step;
   logic                            last_step;
   logic                            step;
   logic                            accept;

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      adj = bcd_ff;
      for (int d = 0; d < bcdso_pkg::BCD_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end
      end
      bcd_step = {adj[bcdso_pkg::BCD_W-2:0], bin_ff[bcdso_pkg::VALUE_W-1]};
   end

   assign last_step = (cnt_ff == bcdso_pkg::STEP_W'(bcdso_pkg::VALUE_W - 1));
   assign step      = busy_ff && (!last_step || !q_stat.full);
   assign push      = step && last_step;
   assign req_tready = !busy_ff || push;
   assign accept    = req_tvalid && req_tready;

   // keep the known digits only: this drops the ten-thousands digit
   always_comb begin
      push_data = '0;
      for (int d = 0; d < bcdso_pkg::DIGITS; d++) begin
         if (d < bcdso_pkg::KNOWN_DIGITS) begin
            push_data[d*4 +: 4] = bcd_step[d*4 +: 4];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (step) begin
         cnt_in = cnt_ff + 1'b1;
         bin_in = {bin_ff[bcdso_pkg::VALUE_W-2:0], 1'b0};
         bcd_in = bcd_step;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = req_value;
         bcd_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

### rtl/bcdso_queue.sv
// ----------------------------------------------------------------------------
// bcdso_queue
// Short FIFO of converted digit sets between front and back.
// ----------------------------------------------------------------------------
module bcdso_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bcdso_pkg::digits_type push_data,
   input  logic                  pop,
   output bcdso_pkg::digits_type pop_data,
   output bcdso_pkg::q_stat_type q_stat
);

   bcdso_pkg::digits_type          mem_ff [bcdso_pkg::QUEUE_DEPTH];
   logic [bcdso_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bcdso_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bcdso_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign q_stat.full  = (count_ff == bcdso_pkg::QCNT_W'(bcdso_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bcdso_back.sv
// ----------------------------------------------------------------------------
// bcdso_back
// Serializes one digit set per run: digits least significant first, bits
// most significant first, then a latch beat. Output is registered.
// ----------------------------------------------------------------------------
module bcdso_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bcdso_pkg::q_stat_type q_stat,
   input  bcdso_pkg::digits_type pop_data,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_serial_data,
   output logic                  rsp_is_latch,
   output logic                  rsp_last_of_run
);

   logic                              active_ff, active_in;
   bcdso_pkg::digits_type             sr_ff, sr_in;
   logic [bcdso_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic                              valid_ff, valid_in;
   logic                              data_ff, data_in;
   logic                              latch_ff, latch_in;
   logic                              last_ff, last_in;
   bcdso_pkg::digits_type             seq;
   logic                              adv;
   logic                              emit;
   logic                              at_latch;

   // lay the bits out in send order, first beat in the top bit
   always_comb begin
      seq = '0;
      for (int d = 0; d < bcdso_pkg::DIGITS; d++) begin
         for (int b = 0; b < bcdso_pkg::BITS_PER_DIGIT; b++) begin
            seq[bcdso_pkg::BIT_COUNT - 4 - d*4 + b] = pop_data[d*4 + b];
         end
      end
   end

   assign adv      = !valid_ff || rsp_tready;
   assign emit     = active_ff && adv;
   assign at_latch = (pos_ff == bcdso_pkg::POS_W'(bcdso_pkg::BIT_COUNT));
   assign pop      = adv && !q_stat.empty && (!active_ff || at_latch);

   always_comb begin
      active_in = active_ff;
      sr_in     = sr_ff;
      pos_in    = pos_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      latch_in  = latch_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         data_in  = at_latch ? 1'b0 : sr_ff[bcdso_pkg::BIT_COUNT-1];
         latch_in = at_latch;
         last_in  = at_latch;
         sr_in    = {sr_ff[bcdso_pkg::BIT_COUNT-2:0], 1'b0};
         pos_in   = pos_ff + 1'b1;
         if (at_latch) begin
            active_in = 1'b0;
         end
      end else if (adv) begin
         valid_in = 1'b0;
      end
      // load the next run right behind the latch beat
      if (pop) begin
         active_in = 1'b1;
         sr_in     = seq;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         pos_ff    <= pos_in;
      end
      sr_ff    <= sr_in;
      data_ff  <= data_in;
      latch_ff <= latch_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_serial_data = data_ff;
   assign rsp_is_latch    = latch_ff;
   assign rsp_last_of_run = last_ff;

endmodule

### rtl/bcd_digit_shift_out_driver.sv
// Path: a value passes through the double-dabble steps, the queue pop and
//   the output register before the first beat of its run.
// Throughput: 17 beats per value, one per cycle while rsp_tready is high; the
//   serializer sets this, the converter runs ahead through a 2-deep queue.
// Reset: synchronous, active high; clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
// bcd_digit_shift_out_driver
// Converts a 16-bit value to four decimal digits (modulo 10000) and sends
// them as shift-clock bit beats followed by one latch beat.
// ----------------------------------------------------------------------------
module bcd_digit_shift_out_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] serial_data, [7:1] zero
   output logic        rsp_tuser,   // [0] is_latch
   output logic        rsp_tlast    // last_of_run
);

   bcdso_pkg::q_stat_type q_stat;
   bcdso_pkg::digits_type push_data;
   bcdso_pkg::digits_type pop_data;
   logic                  push;
   logic                  pop;
   logic                  serial_data;

   bcdso_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[bcdso_pkg::VALUE_W-1:0]),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   bcdso_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   bcdso_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_serial_data (serial_data),
      .rsp_is_latch    (rsp_tuser),
      .rsp_last_of_run (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, serial_data};

endmodule
